@@ rtl/core/sxf_pkg.sv @@
// ----------------------------------------------------------------------------
// sxf_pkg: shared types and helpers for the stereo crossfeed filter
// Register codes, mode codes, lane control and lane result structs, and
// the s0.31 fractional multiply used by every lane.
// ----------------------------------------------------------------------------
package sxf_pkg;

   localparam int DATA_W           = 32;
   localparam int MAX_DELAY_DEF    = 32;
   localparam int SAMPLE_WIDTH_DEF = 32;
   localparam int COEF_U_W         = 31;
   localparam int DLEN_W           = 6;
   localparam int KIND_W           = 2;
   localparam int CSR_INDEX_W      = 3;
   localparam int CSR_DATA_W       = 32;

   localparam logic [COEF_U_W-1:0] GAIN_RESET = 31'h7fff_ffff;
   localparam logic [DLEN_W-1:0]   DLEN_RESET = 6'd13;

   typedef enum logic [KIND_W-1:0] {
      KIND_BYPASS  = 2'd0,
      KIND_PASSIVE = 2'd1,
      KIND_CUSTOM  = 2'd2
   } kind_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_KIND    = 3'd0,
      CSR_GAIN    = 3'd1,
      CSR_B0      = 3'd2,
      CSR_B1      = 3'd3,
      CSR_A1      = 3'd4,
      CSR_FORWARD = 3'd5,
      CSR_CROSS   = 3'd6,
      CSR_DELAY   = 3'd7
   } csr_index_type;

   typedef struct packed {
      logic                     mode;
      logic signed [DATA_W-1:0] in_left;
      logic signed [DATA_W-1:0] in_right;
   } req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] out_left;
      logic signed [DATA_W-1:0] out_right;
   } rsp_type;

   typedef struct packed {
      logic [KIND_W-1:0]        kind;
      logic [COEF_U_W-1:0]      direct_gain;
      logic signed [DATA_W-1:0] coef_b0;
      logic signed [DATA_W-1:0] coef_b1;
      logic signed [DATA_W-1:0] coef_a1;
      logic [COEF_U_W-1:0]      forward_coef;
      logic [COEF_U_W-1:0]      cross_coef;
      logic [DLEN_W-1:0]        delay_length;
   } cfg_type;

   typedef struct packed {
      logic custom;
      logic passive;
      logic emit;
      logic flush;
   } step_ctrl_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] own;
      logic signed [DATA_W-1:0] filt;
   } lane_out_type;

   // (a*b)>>31, arithmetic, low 32 bits kept
   function automatic logic signed [DATA_W-1:0] fmul(input logic signed [DATA_W-1:0] a,
                                                     input logic signed [DATA_W-1:0] b);
      logic signed [2*DATA_W-1:0] prod;
      prod = a * b;
      return prod[2*DATA_W-2:DATA_W-1];
   endfunction

endpackage

@@ rtl/core/sxf_stream_if.sv @@
// ----------------------------------------------------------------------------
// sxf_stream_if: valid/ready stream channel
// Carries one payload of a chosen type per accepted request.
// ----------------------------------------------------------------------------
interface sxf_stream_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

@@ rtl/core/sxf_ram.sv @@
// ----------------------------------------------------------------------------
// sxf_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module sxf_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

@@ rtl/core/sxf_lane.sv @@
// ----------------------------------------------------------------------------
// sxf_lane: one channel of the crossfeed core
// Holds the shelf filter history and the passive capacitor state of one
// channel and computes its direct term and new filter output.
// ----------------------------------------------------------------------------
module sxf_lane #(
   parameter int SAMPLE_WIDTH = sxf_pkg::SAMPLE_WIDTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  sxf_pkg::step_ctrl_type        ctrl,
   input  sxf_pkg::cfg_type              cfg,
   input  logic [SAMPLE_WIDTH-1:0]       sample,
   input  logic [SAMPLE_WIDTH-1:0]       delayed,
   input  logic [sxf_pkg::DATA_W-1:0]    couple,
   output sxf_pkg::lane_out_type         result
);
   import sxf_pkg::*;

   logic [SAMPLE_WIDTH-1:0] prev_in_ff, prev_in_in;
   logic [SAMPLE_WIDTH-1:0] prev_out_ff, prev_out_in;
   logic [SAMPLE_WIDTH-1:0] cap_ff, cap_in;
   logic signed [DATA_W-1:0] filt_sum;
   logic signed [DATA_W-1:0] cap_sum;

   function automatic logic signed [DATA_W-1:0] sext(input logic [SAMPLE_WIDTH-1:0] v);
      return DATA_W'(signed'(v));
   endfunction

   always_comb begin
      filt_sum = fmul(sext(delayed), cfg.coef_b0) + fmul(sext(prev_in_ff), cfg.coef_b1)
               + fmul(sext(prev_out_ff), cfg.coef_a1);
      cap_sum  = sext(cap_ff) - (fmul(sext(cap_ff), signed'({1'b0, cfg.forward_coef}))
               + signed'(couple));
      prev_in_in  = prev_in_ff;
      prev_out_in = prev_out_ff;
      cap_in      = cap_ff;
      if (ctrl.flush) begin
         prev_in_in  = '0;
         prev_out_in = '0;
         cap_in      = '0;
      end else if (ctrl.custom) begin
         prev_in_in  = delayed;
         prev_out_in = filt_sum[SAMPLE_WIDTH-1:0];
      end else if (ctrl.passive) begin
         cap_in = cap_sum[SAMPLE_WIDTH-1:0];
      end
   end

   always_comb begin
      result.filt = sext(filt_sum[SAMPLE_WIDTH-1:0]);
      if (ctrl.custom) begin
         result.own = fmul(sext(sample), signed'({1'b0, cfg.direct_gain}));
      end else if (ctrl.passive) begin
         result.own = sext(sample) + sext(cap_ff);
      end else begin
         result.own = sext(sample);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_in_ff  <= '0;
         prev_out_ff <= '0;
         cap_ff      <= '0;
      end else begin
         prev_in_ff  <= prev_in_in;
         prev_out_ff <= prev_out_in;
         cap_ff      <= cap_in;
      end
   end
endmodule

@@ rtl/core/sxf_merge.sv @@
// ----------------------------------------------------------------------------
// sxf_merge: lane merge and output register
// Crosses the filtered paths between channels, keeps the passive difference
// signal and drives the response register.
// ----------------------------------------------------------------------------
module sxf_merge #(
   parameter int SAMPLE_WIDTH = sxf_pkg::SAMPLE_WIDTH_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  sxf_pkg::step_ctrl_type     ctrl,
   input  sxf_pkg::cfg_type           cfg,
   input  sxf_pkg::lane_out_type      lane_l,
   input  sxf_pkg::lane_out_type      lane_r,
   output logic [sxf_pkg::DATA_W-1:0] couple_l,
   output logic [sxf_pkg::DATA_W-1:0] couple_r,
   output logic                       out_free,
   sxf_stream_if.source               rsp
);
   import sxf_pkg::*;

   logic [SAMPLE_WIDTH-1:0] diff_ff, diff_in;
   logic [SAMPLE_WIDTH-1:0] left_ff, left_in;
   logic [SAMPLE_WIDTH-1:0] right_ff, right_in;
   logic                    valid_ff, valid_in;
   logic signed [DATA_W-1:0] common;
   logic signed [DATA_W-1:0] sum_l, sum_r;

   function automatic logic signed [DATA_W-1:0] sext(input logic [SAMPLE_WIDTH-1:0] v);
      return DATA_W'(signed'(v));
   endfunction

   always_comb begin
      common   = fmul(sext(diff_ff), signed'({1'b0, cfg.cross_coef}));
      couple_l = common;
      couple_r = -common;
      if (ctrl.custom) begin
         sum_l = lane_l.own + lane_r.filt;
         sum_r = lane_r.own + lane_l.filt;
      end else begin
         sum_l = lane_l.own;
         sum_r = lane_r.own;
      end
      left_in  = ctrl.emit ? sum_l[SAMPLE_WIDTH-1:0] : left_ff;
      right_in = ctrl.emit ? sum_r[SAMPLE_WIDTH-1:0] : right_ff;
      diff_in  = diff_ff;
      if (ctrl.flush) begin
         diff_in = '0;
      end else if (ctrl.passive) begin
         diff_in = sum_l[SAMPLE_WIDTH-1:0] - sum_r[SAMPLE_WIDTH-1:0];
      end
      if (ctrl.emit) begin
         valid_in = 1'b1;
      end else if (rsp.ready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   assign out_free              = !valid_ff || rsp.ready;
   assign rsp.valid             = valid_ff;
   assign rsp.payload.out_left  = sext(left_ff);
   assign rsp.payload.out_right = sext(right_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         diff_ff  <= '0;
      end else begin
         valid_ff <= valid_in;
         diff_ff  <= diff_in;
      end
      left_ff  <= left_in;
      right_ff <= right_in;
   end
endmodule

@@ rtl/core/stereo_crossfeed_filter_unit.sv @@
// ----------------------------------------------------------------------------
// stereo_crossfeed_filter_unit: headphone crossfeed on stereo sample pairs
// Bypass, passive two-pole and custom delay plus shelf filter modes.
// ----------------------------------------------------------------------------
// Requests arrive on req_chan (valid/ready): mode 0 carries a sample pair,
// mode 1 is a flush that clears the filter histories, capacitor states,
// difference signal, delay line and delay pointer and gives no response.
// Each sample pair gives one response pair on rsp_chan (valid/ready).
// Registers are written through csr_wr_en, csr_index and csr_wr_data; the
// user must do so only while no request is in flight, which the block itself
// does not enforce. A taken request waits in the stage register, and its
// response is then registered in the response register. Throughput: one
// request per cycle unless rsp_chan stalls; the stage register reads the
// delay RAM at accept, the left and right lanes finish their multiply-add and
// feedback update as the stage moves on, forwarding a just-written slot on a reread.
// Reset clears the registers to their defaults and all histories; the delay
// line reads as zero through per-slot valid bits, so there is no clearing
// pass. When rsp_chan stalls the response register holds, the stage behind
// it fills and then req_chan.ready drops; nothing is lost.
// ----------------------------------------------------------------------------
module stereo_crossfeed_filter_unit #(
   parameter int MAX_DELAY    = sxf_pkg::MAX_DELAY_DEF,
   parameter int SAMPLE_WIDTH = sxf_pkg::SAMPLE_WIDTH_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   sxf_stream_if.sink                      req_chan,
   sxf_stream_if.source                    rsp_chan,
   input  logic                            csr_wr_en,
   input  logic [sxf_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [sxf_pkg::CSR_DATA_W-1:0]  csr_wr_data
);
   import sxf_pkg::*;

   localparam int PTR_W = $clog2(MAX_DELAY);
   localparam int CMP_W = (DLEN_W > PTR_W + 1) ? DLEN_W : PTR_W + 1;
   localparam int RAM_W = 2 * SAMPLE_WIDTH;

   cfg_type cfg_ff, cfg_in;

   logic [PTR_W-1:0]        ptr_ff, ptr_in;
   logic [MAX_DELAY-1:0]    valid_ff, valid_in;
   logic                    s1_valid_ff, s1_valid_in;
   logic                    s1_flush_ff;
   logic [SAMPLE_WIDTH-1:0] s1_left_ff, s1_right_ff;
   logic [PTR_W-1:0]        s1_addr_ff;
   logic                    s1_rdv_ff, s1_fwd_ff;
   logic [RAM_W-1:0]        s1_fwd_data_ff;

   logic             req_fire, s1_go, out_free, hit, rdv;
   logic [CMP_W-1:0] dlen_ext, len, ptr_inc;
   logic [PTR_W-1:0] ptr_next;
   logic [RAM_W-1:0] ram_rd, delayed, wr_data;
   step_ctrl_type    step;
   lane_out_type     lane_l, lane_r;
   logic [DATA_W-1:0] couple_l, couple_r;

   // configuration registers
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_index_type'(csr_index))
            CSR_KIND:    cfg_in.kind         = csr_wr_data[KIND_W-1:0];
            CSR_GAIN:    cfg_in.direct_gain  = csr_wr_data[COEF_U_W-1:0];
            CSR_B0:      cfg_in.coef_b0      = signed'(csr_wr_data[DATA_W-1:0]);
            CSR_B1:      cfg_in.coef_b1      = signed'(csr_wr_data[DATA_W-1:0]);
            CSR_A1:      cfg_in.coef_a1      = signed'(csr_wr_data[DATA_W-1:0]);
            CSR_FORWARD: cfg_in.forward_coef = csr_wr_data[COEF_U_W-1:0];
            CSR_CROSS:   cfg_in.cross_coef   = csr_wr_data[COEF_U_W-1:0];
            CSR_DELAY:   cfg_in.delay_length = csr_wr_data[DLEN_W-1:0];
         endcase
      end
   end

   // handshake and lane control
   assign s1_go          = s1_valid_ff && (s1_flush_ff || out_free);
   assign req_chan.ready = !s1_valid_ff || s1_go;
   assign req_fire       = req_chan.valid && req_chan.ready;

   assign step.emit    = s1_go && !s1_flush_ff;
   assign step.flush   = s1_go && s1_flush_ff;
   assign step.custom  = step.emit && (cfg_ff.kind == KIND_CUSTOM);
   assign step.passive = step.emit && (cfg_ff.kind == KIND_PASSIVE);

   // delay pointer with wrap at the clamped length
   always_comb begin
      dlen_ext = CMP_W'(cfg_ff.delay_length);
      if (dlen_ext == '0) begin
         len = CMP_W'(1);
      end else if (dlen_ext > CMP_W'(MAX_DELAY)) begin
         len = CMP_W'(MAX_DELAY);
      end else begin
         len = dlen_ext;
      end
      ptr_inc  = CMP_W'(ptr_ff) + CMP_W'(1);
      ptr_next = (ptr_inc >= len) ? '0 : ptr_inc[PTR_W-1:0];
      ptr_in   = ptr_ff;
      if (req_fire && req_chan.payload.mode) begin
         ptr_in = '0;
      end else if (req_fire && (cfg_ff.kind == KIND_CUSTOM)) begin
         ptr_in = ptr_next;
      end
   end

   // delay line write, forwarding and slot valid bits
   assign wr_data = {s1_right_ff, s1_left_ff};
   assign hit     = step.custom && (s1_addr_ff == ptr_ff);
   assign rdv     = (valid_ff[ptr_ff] && !step.flush) || hit;

   always_comb begin
      valid_in = valid_ff;
      if (step.flush) begin
         valid_in = '0;
      end else if (step.custom) begin
         valid_in[s1_addr_ff] = 1'b1;
      end
   end

   always_comb begin
      if (!s1_rdv_ff) begin
         delayed = '0;
      end else if (s1_fwd_ff) begin
         delayed = s1_fwd_data_ff;
      end else begin
         delayed = ram_rd;
      end
   end

   assign s1_valid_in = req_fire ? 1'b1 : (s1_go ? 1'b0 : s1_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.kind         <= KIND_BYPASS;
         cfg_ff.direct_gain  <= GAIN_RESET;
         cfg_ff.coef_b0      <= '0;
         cfg_ff.coef_b1      <= '0;
         cfg_ff.coef_a1      <= '0;
         cfg_ff.forward_coef <= '0;
         cfg_ff.cross_coef   <= '0;
         cfg_ff.delay_length <= DLEN_RESET;
         ptr_ff              <= '0;
         valid_ff            <= '0;
         s1_valid_ff         <= 1'b0;
      end else begin
         cfg_ff      <= cfg_in;
         ptr_ff      <= ptr_in;
         valid_ff    <= valid_in;
         s1_valid_ff <= s1_valid_in;
      end
      if (req_fire) begin
         s1_flush_ff    <= req_chan.payload.mode;
         s1_left_ff     <= req_chan.payload.in_left[SAMPLE_WIDTH-1:0];
         s1_right_ff    <= req_chan.payload.in_right[SAMPLE_WIDTH-1:0];
         s1_addr_ff     <= ptr_ff;
         s1_rdv_ff      <= rdv;
         s1_fwd_ff      <= hit;
         s1_fwd_data_ff <= wr_data;
      end
   end

   sxf_ram #(
      .WIDTH (RAM_W),
      .DEPTH (MAX_DELAY)
   ) u_delay_ram (
      .clock   (clock),
      .wr_en   (step.custom),
      .wr_addr (s1_addr_ff),
      .wr_data (wr_data),
      .rd_en   (req_fire),
      .rd_addr (ptr_ff),
      .rd_data (ram_rd)
   );

   sxf_lane #(
      .SAMPLE_WIDTH (SAMPLE_WIDTH)
   ) u_lane_left (
      .clock   (clock),
      .reset   (reset),
      .ctrl    (step),
      .cfg     (cfg_ff),
      .sample  (s1_left_ff),
      .delayed (delayed[SAMPLE_WIDTH-1:0]),
      .couple  (couple_l),
      .result  (lane_l)
   );

   sxf_lane #(
      .SAMPLE_WIDTH (SAMPLE_WIDTH)
   ) u_lane_right (
      .clock   (clock),
      .reset   (reset),
      .ctrl    (step),
      .cfg     (cfg_ff),
      .sample  (s1_right_ff),
      .delayed (delayed[RAM_W-1:SAMPLE_WIDTH]),
      .couple  (couple_r),
      .result  (lane_r)
   );

   sxf_merge #(
      .SAMPLE_WIDTH (SAMPLE_WIDTH)
   ) u_merge (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (step),
      .cfg      (cfg_ff),
      .lane_l   (lane_l),
      .lane_r   (lane_r),
      .couple_l (couple_l),
      .couple_r (couple_r),
      .out_free (out_free),
      .rsp      (rsp_chan)
   );

   // a stalled stage keeps its slot address and read data selection
   a_stage_hold: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !s1_go |=> s1_valid_ff && $stable(s1_addr_ff) && $stable(s1_fwd_ff))
      else $error("stalled request stage changed");

   // forwarded data always counts as a written slot
   a_fwd_valid: assert property (@(posedge clock) disable iff (reset)
      s1_fwd_ff |-> s1_rdv_ff)
      else $error("forwarded slot not marked valid");

   // a flush request resets the delay pointer
   a_flush_ptr: assert property (@(posedge clock) disable iff (reset)
      req_fire && req_chan.payload.mode |=> ptr_ff == '0)
      else $error("delay pointer not cleared by flush");

   // a flush leaving the stage leaves no written slot behind
   a_flush_valid: assert property (@(posedge clock) disable iff (reset)
      step.flush |=> valid_ff == '0)
      else $error("slot valid bits not cleared by flush");

   // backpressure only comes from a held stage
   a_ready: assert property (@(posedge clock) disable iff (reset)
      !req_chan.ready |-> s1_valid_ff && !s1_flush_ff && rsp_chan.valid)
      else $error("request stalled without a pending response");
endmodule
